// ===== sv/fixed_block_pool_free_list_macros.svh =====
// Assertion macros shared by the fixed block pool free list RTL.
`ifndef FIXED_BLOCK_POOL_FREE_LIST_MACROS_SVH
`define FIXED_BLOCK_POOL_FREE_LIST_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define FBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fixed block pool: assertion failed");
// Check a property on every clock edge, reset included.
`define FBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fixed block pool: assertion failed");
`else
`define FBP_ASSERT(lbl, prop)
`define FBP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/fbp_pkg.sv =====
// Package: types, constants and helpers of the fixed block pool free list.
`timescale 1ns / 1ps
package fbp_pkg;

  localparam int POOL_DEPTH = 256;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = IDX_W + 1;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  localparam int REQ_W   = 2;
  localparam int FIDX_W  = 8;
  localparam int BIDX_W  = 8;
  localparam int OFF_W   = 24;
  localparam int PSIZE_W = 9;
  localparam int OSIZE_W = 17;

  localparam logic [PSIZE_W-1:0] POOL_SIZE_RST   = 9'd256;
  localparam logic [OSIZE_W-1:0] OBJECT_SIZE_RST = 17'd64;
  localparam logic [OSIZE_W-1:0] MIN_OBJECT      = 17'd8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE = 1'b1;

  // Request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REINIT = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FIDX_W-1:0] idx;
  } cmd_t;

  // Blocks linked by an init walk: pool size clamped to the pool depth.
  function automatic logic [LINK_W-1:0] sat_pool(input logic [PSIZE_W-1:0] ps);
    logic [LINK_W-1:0] n;
    n = (32'(ps) > POOL_DEPTH) ? LINK_W'(POOL_DEPTH) : LINK_W'(ps);
    return n;
  endfunction

endpackage

// ===== sv/fbp_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fbp_front.sv =====
// Front end: accept requests, classify them and queue commands for the executor.
`timescale 1ns / 1ps
module fbp_front import fbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [FIDX_W-1:0] free_index,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       cls;

  // Classify; a free of an index beyond the pool depth becomes a no-op.
  always_comb begin
    cls.idx = free_index;
    case (req_type)
      REQ_ALLOC:  cls.op = OP_ALLOC;
      REQ_FREE:   cls.op = (32'(free_index) < POOL_DEPTH) ? OP_FREE : OP_NOP;
      REQ_REINIT: cls.op = OP_REINIT;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`include "fixed_block_pool_free_list_macros.svh"

  `FBP_ASSERT(a_front_empty_push_shows, (push && count == 2'd0) |=> cmd_valid)
  `FBP_ASSERT(a_front_no_push_when_full, (count == 2'd2) |-> !push)

endmodule

// ===== sv/fbp_back.sv =====
// Executor: run allocate, free and reinit against the link memory.
`timescale 1ns / 1ps
module fbp_back import fbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  input  logic [PSIZE_W-1:0] pool_size,
  input  logic [OSIZE_W-1:0] object_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BIDX_W-1:0]  block_index,
  output logic [OFF_W-1:0]   byte_offset,
  output logic               status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  head_index;
  logic              list_empty;
  logic [LINK_W-1:0] init_count;
  logic [POOL_DEPTH-1:0] link_vld;

  logic [LINK_W-1:0] dflt_link;
  logic              vld_seen;
  logic [OFF_W-1:0]  prod;

  logic              out_free;
  logic              go;
  logic              alloc_hit;
  logic              ram_we;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;
  logic [LINK_W-1:0] succ;
  logic [LINK_W-1:0] nxt;
  logic [LINK_W-1:0] reinit_n;
  logic [OSIZE_W-1:0] osz;

  logic              load_out;
  logic [BIDX_W-1:0] out_idx_d;
  logic [OFF_W-1:0]  out_off_d;
  logic              out_stat_d;

  assign out_free  = !out_valid || out_ready;
  assign go        = (state == ST_IDLE) && cmd_valid && out_free;
  assign cmd_ready = go;
  assign alloc_hit = go && (cmd.op == OP_ALLOC) && !list_empty;

  assign ram_we    = go && (cmd.op == OP_FREE);
  assign ram_wdata = list_empty ? LINK_NULL : LINK_W'(head_index);

  fbp_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.idx[IDX_W-1:0]),
    .wdata (ram_wdata),
    .re    (alloc_hit),
    .raddr (head_index),
    .rdata (ram_rdata)
  );

  // Link of an entry untouched since the last walk.
  assign succ     = LINK_W'(head_index) + LINK_W'(1);
  assign nxt      = vld_seen ? ram_rdata : dflt_link;
  assign reinit_n = sat_pool(pool_size);
  assign osz      = (object_size < MIN_OBJECT) ? MIN_OBJECT : object_size;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (alloc_hit) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    load_out   = 1'b0;
    out_idx_d  = '0;
    out_off_d  = '0;
    out_stat_d = 1'b0;
    if (state == ST_LOOK) begin
      load_out  = 1'b1;
      out_idx_d = BIDX_W'(head_index);
      out_off_d = prod;
    end else if (go && !alloc_hit) begin
      load_out   = 1'b1;
      out_stat_d = (cmd.op == OP_ALLOC);
    end
  end

  // Alloc issue stage: latch default link, valid bit and offset product; load the output register on load_out.
  always_ff @(posedge clk) begin
    if (alloc_hit) begin
      dflt_link <= (succ < init_count) ? succ : LINK_NULL;
      vld_seen  <= link_vld[head_index];
      prod      <= OFF_W'(head_index) * OFF_W'(osz);
    end
    if (load_out) begin
      block_index <= out_idx_d;
      byte_offset <= out_off_d;
      status      <= out_stat_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      head_index <= '0;
      list_empty <= (sat_pool(POOL_SIZE_RST) == '0);
      init_count <= sat_pool(POOL_SIZE_RST);
      link_vld   <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_LOOK) begin
        if (nxt >= LINK_NULL) begin
          list_empty <= 1'b1;
          head_index <= '0;
        end else begin
          head_index <= nxt[IDX_W-1:0];
        end
      end else if (go) begin
        case (cmd.op)
          OP_FREE: begin
            link_vld[cmd.idx[IDX_W-1:0]] <= 1'b1;
            head_index <= cmd.idx[IDX_W-1:0];
            list_empty <= 1'b0;
          end
          OP_REINIT: begin
            link_vld   <= '0;
            head_index <= '0;
            list_empty <= (reinit_n == '0);
            init_count <= reinit_n;
          end
          default: begin
          end
        endcase
      end
    end
  end

`include "fixed_block_pool_free_list_macros.svh"

  `FBP_ASSERT(a_back_look_slot_free, (state == ST_LOOK) |-> !out_valid)
  `FBP_ASSERT(a_back_look_one_cycle, (state == ST_LOOK) |=> (state == ST_IDLE && out_valid))
  `FBP_ASSERT(a_back_exhaust_zero, (out_valid && status) |-> (block_index == '0 && byte_offset == '0))

endmodule

// ===== sv/fixed_block_pool_free_list.sv =====
// Top level of the fixed block pool free list allocator.
`timescale 1ns / 1ps
// Usage
//   Request channel (in_valid/in_ready, req_type, free_index): each word is an
//   allocate, a free of free_index, or a reinit of the free list. Every word
//   gives exactly one result word on the out channel (out_valid/out_ready,
//   block_index, byte_offset, status); status is 1 when an allocate finds the
//   pool exhausted. Results come back in request order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   index 0 is pool_size, index 1 is object_size. Both take effect at the
//   next reinit (pool_size) or at once for offsets (object_size). Write only
//   while the block is idle.
// Timing
//   A two-entry command queue sits between the front end and the executor.
//   The executor loads its result register on taking a free, a reinit or an
//   exhausted allocate; a successful allocate first passes through ST_LOOK
//   for the synchronous read of the link memory.
// Reset
//   Reset leaves the list linked 0..255 with head 0: per-entry
//   valid bits stand in for the init walk, so no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills, and in_ready drops after two more words.
module fixed_block_pool_free_list import fbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [FIDX_W-1:0]    free_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BIDX_W-1:0]    block_index,
  output logic [OFF_W-1:0]     byte_offset,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OSIZE_W-1:0]   cfg_data
);

  logic [PSIZE_W-1:0] pool_size;
  logic [OSIZE_W-1:0] object_size;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;

  // Config writes never stall.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= POOL_SIZE_RST;
      object_size <= OBJECT_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL_SIZE:   pool_size   <= cfg_data[PSIZE_W-1:0];
        CFG_OBJECT_SIZE: object_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: classify and queue requests.
  fbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .free_index (free_index),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Executor: owns the head, the link memory and the output register.
  fbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .pool_size   (pool_size),
    .object_size (object_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_index (block_index),
    .byte_offset (byte_offset),
    .status      (status)
  );

endmodule
